// ===== src/sample_moving_average_macros.svh =====
// Assertion macros shared by the moving average block.
`ifndef SAMPLE_MOVING_AVERAGE_MACROS_SVH
`define SAMPLE_MOVING_AVERAGE_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define SMA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define SMA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/sma_pkg.sv =====
// Shared constants and control types of the moving average block.
`timescale 1ns / 1ps

package sma_pkg;

	localparam int SMA_RING_DEPTH = 64;
	localparam int SMA_SAMPLE_W   = 16;
	localparam int SMA_HELD_W     = 7;
	localparam int SMA_WIN_W      = 7;
	localparam logic [SMA_WIN_W-1:0] SMA_WIN_RESET = 7'd16;

	// Per-cycle commands from the sequencer to the datapath.
	typedef struct packed {
		logic                  load_sample;
		logic                  clr_sum;
		logic                  sub_old;
		logic                  add_new;
		logic                  take_abs;
		logic                  div_step;
		logic                  negate;
		logic [SMA_HELD_W-1:0] divisor;
	} sma_ctl_t;

endpackage

// ===== src/sample_moving_average.sv =====
// Each accepted sample enters a ring of recent samples and updates a running sum; the block
// returns one beat per sample with the sum divided by the number of samples held (truncated
// toward zero) and that count. Until window_length samples have been seen the average covers
// all samples so far; a window of zero acts as one and a window beyond the ring depth as the
// ring depth. Writing window_length restarts warm-up. From acceptance to the next ready a sample
// passes through a ring read, sum update, magnitude, one quotient bit per cycle through the
// single shared add/subtract unit, sign fix and result hand-off. The next sample is taken
// while the result beat still waits.
`timescale 1ns / 1ps

`include "sample_moving_average_macros.svh"

module sample_moving_average #(
	parameter int RING_DEPTH = sma_pkg::SMA_RING_DEPTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wen,
	input  logic [sma_pkg::SMA_WIN_W-1:0] cfg_wdata,      // window_length
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [15:0]                   s_tdata,        // [15:0] sample
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [23:0]                   m_tdata         // [15:0] average, [22:16] samples_held
);

	import sma_pkg::*;

	localparam int MAXWIN = (RING_DEPTH < 127) ? RING_DEPTH : 127;
	localparam int SUM_W  = SMA_SAMPLE_W + $clog2(MAXWIN);
	localparam int AW     = $clog2(RING_DEPTH);

	sma_ctl_t                  ctl;
	logic                      out_free;
	logic                      out_load;
	logic                      ram_we;
	logic                      ram_re;
	logic [AW-1:0]             ram_waddr;
	logic [AW-1:0]             ram_raddr;
	logic [SMA_SAMPLE_W-1:0]   ram_rdata;
	logic [SMA_SAMPLE_W-1:0]   sample_held;
	logic [SMA_SAMPLE_W-1:0]   average;
	logic [SMA_HELD_W-1:0]     held_count;

	logic                      m_valid_q;
	logic [SMA_SAMPLE_W-1:0]   avg_q;
	logic [SMA_HELD_W-1:0]     held_out_q;

	assign out_free = !m_valid_q || m_tready;

	sma_seq #(
		.RING_DEPTH (RING_DEPTH),
		.SUM_W      (SUM_W)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wen    (cfg_wen),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.out_free   (out_free),
		.out_load   (out_load),
		.ctl        (ctl),
		.ram_we     (ram_we),
		.ram_waddr  (ram_waddr),
		.ram_re     (ram_re),
		.ram_raddr  (ram_raddr),
		.held_count (held_count)
	);

	sma_dp #(
		.SUM_W (SUM_W)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.sample      (s_tdata),
		.ring_rdata  (ram_rdata),
		.sample_held (sample_held),
		.average     (average)
	);

	sma_ram #(
		.WIDTH (SMA_SAMPLE_W),
		.DEPTH (RING_DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (sample_held),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Output beat valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	// Output beat payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			avg_q      <= average;
			held_out_q <= held_count;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {1'b0, held_out_q, avg_q};

	`SMA_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "ready stayed high after a sample beat")
	`SMA_ASSERT_NOW(a_held_in_range, m_valid_q, (held_out_q != '0) && (held_out_q <= SMA_HELD_W'(MAXWIN)), "samples_held out of range")
	`SMA_ASSERT_NEXT(a_idle_after_load, out_load, s_tready && m_valid_q, "result load did not return to idle")

endmodule

// ===== src/sma_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module sma_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== src/sma_dp.sv =====
// Datapath: running sum, divider registers and the one shared add/subtract unit.
`timescale 1ns / 1ps

module sma_dp #(
	parameter int SUM_W = 22
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  sma_pkg::sma_ctl_t                      ctl,
	input  logic signed [sma_pkg::SMA_SAMPLE_W-1:0] sample,
	input  logic signed [sma_pkg::SMA_SAMPLE_W-1:0] ring_rdata,
	output logic signed [sma_pkg::SMA_SAMPLE_W-1:0] sample_held,
	output logic signed [sma_pkg::SMA_SAMPLE_W-1:0] average
);

	import sma_pkg::*;

	localparam int UW = SUM_W + 1;
	localparam int EXT_W = UW - SMA_SAMPLE_W;

	logic signed [SUM_W-1:0]        sum_q;
	logic signed [SMA_SAMPLE_W-1:0] sample_q;
	logic [SUM_W-1:0]               work_q;
	logic [SMA_HELD_W-1:0]          rem_q;
	logic                           neg_q;

	logic [UW-1:0]         op_a;
	logic [UW-1:0]         op_b;
	logic                  op_sub;
	logic [UW-1:0]         op_res;
	logic [SMA_HELD_W:0]   rem_sh;
	logic                  trial_ok;

	assign rem_sh   = {rem_q, work_q[SUM_W-1]};
	assign trial_ok = !op_res[UW-1];

	// Select operands for the shared adder
	always_comb begin
		op_a   = '0;
		op_b   = '0;
		op_sub = 1'b0;
		priority if (ctl.sub_old) begin
			op_a   = {sum_q[SUM_W-1], sum_q};
			op_b   = {{EXT_W{ring_rdata[SMA_SAMPLE_W-1]}}, ring_rdata};
			op_sub = 1'b1;
		end else if (ctl.add_new) begin
			op_a   = {sum_q[SUM_W-1], sum_q};
			op_b   = {{EXT_W{sample_q[SMA_SAMPLE_W-1]}}, sample_q};
		end else if (ctl.take_abs) begin
			op_b   = {sum_q[SUM_W-1], sum_q};
			op_sub = sum_q[SUM_W-1];
		end else if (ctl.div_step) begin
			op_a   = {{(UW-SMA_HELD_W-1){1'b0}}, rem_sh};
			op_b   = {{(UW-SMA_HELD_W){1'b0}}, ctl.divisor};
			op_sub = 1'b1;
		end else if (ctl.negate) begin
			op_b   = {1'b0, work_q};
			op_sub = neg_q;
		end
	end

	// Shared add/subtract unit
	assign op_res = op_a + (op_b ^ {UW{op_sub}}) + {{(UW-1){1'b0}}, op_sub};

	// Running sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (ctl.clr_sum) begin
			sum_q <= '0;
		end else if (ctl.sub_old || ctl.add_new) begin
			sum_q <= op_res[SUM_W-1:0];
		end
	end

	// Hold the sample, magnitude, quotient and remainder
	always_ff @(posedge clk) begin
		if (ctl.load_sample) begin
			sample_q <= sample;
		end
		if (ctl.take_abs) begin
			work_q <= op_res[SUM_W-1:0];
			neg_q  <= sum_q[SUM_W-1];
			rem_q  <= '0;
		end else if (ctl.div_step) begin
			work_q <= {work_q[SUM_W-2:0], trial_ok};
			rem_q  <= trial_ok ? op_res[SMA_HELD_W-1:0] : rem_sh[SMA_HELD_W-1:0];
		end else if (ctl.negate) begin
			work_q <= op_res[SUM_W-1:0];
		end
	end

	assign sample_held = sample_q;
	assign average     = work_q[SMA_SAMPLE_W-1:0];

endmodule

// ===== src/sma_seq.sv =====
// Sequencer: window register, ring pointers, held count and step control.
`timescale 1ns / 1ps

module sma_seq #(
	parameter int RING_DEPTH = sma_pkg::SMA_RING_DEPTH,
	parameter int SUM_W      = 22
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wen,
	input  logic [sma_pkg::SMA_WIN_W-1:0]      cfg_wdata,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               out_free,
	output logic                               out_load,
	output sma_pkg::sma_ctl_t                  ctl,
	output logic                               ram_we,
	output logic [$clog2(RING_DEPTH)-1:0]      ram_waddr,
	output logic                               ram_re,
	output logic [$clog2(RING_DEPTH)-1:0]      ram_raddr,
	output logic [sma_pkg::SMA_HELD_W-1:0]     held_count
);

	import sma_pkg::*;

	localparam int AW     = $clog2(RING_DEPTH);
	localparam int IW     = ((AW > SMA_HELD_W) ? AW : SMA_HELD_W) + 1;
	localparam int MAXWIN = (RING_DEPTH < 127) ? RING_DEPTH : 127;
	localparam int CNT_W  = $clog2(SUM_W);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SUB  = 3'd1;
	localparam logic [2:0] ST_ADD  = 3'd2;
	localparam logic [2:0] ST_ABS  = 3'd3;
	localparam logic [2:0] ST_DIV  = 3'd4;
	localparam logic [2:0] ST_NEG  = 3'd5;
	localparam logic [2:0] ST_DONE = 3'd6;

	logic [2:0]            state_q;
	logic [SMA_WIN_W-1:0]  win_q;
	logic [AW-1:0]         wpos_q;
	logic [SMA_HELD_W-1:0] held_q;
	logic                  drop_q;
	logic [CNT_W-1:0]      cnt_q;

	logic [SMA_HELD_W-1:0] eff_win;
	logic [IW-1:0]         wpos_ext;
	logic [IW-1:0]         held_ext;
	logic [IW-1:0]         oldest;
	logic                  accept;

	// Clamp the window to one..ring depth
	always_comb begin
		priority if (win_q == '0) begin
			eff_win = SMA_HELD_W'(1);
		end else if (win_q > SMA_WIN_W'(MAXWIN)) begin
			eff_win = SMA_HELD_W'(MAXWIN);
		end else begin
			eff_win = win_q;
		end
	end

	// Address of the oldest held sample, modulo the ring depth
	assign wpos_ext = IW'(wpos_q);
	assign held_ext = IW'(held_q);
	assign oldest   = (wpos_ext >= held_ext) ? (wpos_ext - held_ext)
	                                         : (wpos_ext + IW'(RING_DEPTH) - held_ext);

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_ready && in_valid;
	assign ram_re    = accept;
	assign ram_raddr = oldest[AW-1:0];
	assign ram_we    = (state_q == ST_SUB);
	assign ram_waddr = wpos_q;
	assign out_load  = (state_q == ST_DONE) && out_free;
	assign held_count = held_q;

	// Decode datapath commands
	always_comb begin
		ctl             = '0;
		ctl.load_sample = accept;
		ctl.clr_sum     = cfg_wen;
		ctl.sub_old     = (state_q == ST_SUB) && drop_q;
		ctl.add_new     = (state_q == ST_ADD);
		ctl.take_abs    = (state_q == ST_ABS);
		ctl.div_step    = (state_q == ST_DIV);
		ctl.negate      = (state_q == ST_NEG);
		ctl.divisor     = held_q;
	end

	// Window register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= SMA_WIN_RESET;
		end else if (cfg_wen) begin
			win_q <= cfg_wdata;
		end
	end

	// Advance the step sequence and ring bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			wpos_q  <= '0;
			held_q  <= '0;
			drop_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			if (cfg_wen) begin
				held_q <= '0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						drop_q  <= (held_q >= eff_win);
						state_q <= ST_SUB;
					end
				end
				ST_SUB: begin
					if (drop_q) begin
						held_q <= held_q - SMA_HELD_W'(1);
					end
					state_q <= ST_ADD;
				end
				ST_ADD: begin
					held_q  <= held_q + SMA_HELD_W'(1);
					wpos_q  <= (wpos_q == AW'(RING_DEPTH - 1)) ? '0 : wpos_q + AW'(1);
					state_q <= ST_ABS;
				end
				ST_ABS: begin
					cnt_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(SUM_W - 1)) begin
						state_q <= ST_NEG;
					end
				end
				ST_NEG: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the moving average block: directed, pressure and random tests.
`timescale 1ns / 1ps

module tb_top;
	import sma_pkg::*;

	localparam int RING          = SMA_RING_DEPTH;
	localparam int SETTLE_CYCLES = 40;    // longer than one sample's trip through the divider
	localparam int RX_HOLD       = 400;   // receiver hold-off that fills the block
	localparam int STALL_LIMIT   = 4000;  // cycles without any beat or window write before the run is abandoned

	logic                 clk;
	logic                 arst_n    = 1'b0;
	logic                 cfg_wen   = 1'b0;
	logic [SMA_WIN_W-1:0] cfg_wdata = '0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [15:0]          s_tdata   = '0;   // [15:0] sample
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [23:0]          m_tdata;          // [15:0] average, [22:16] samples_held

	typedef struct {
		logic signed [15:0]    average;
		logic [SMA_HELD_W-1:0] held;
	} avg_result_t;

	avg_result_t pending_averages[$];

	// Shadow of the block's history and window
	logic signed [15:0] hist_ring [RING];
	int hist_wr;
	int hist_count;
	int hist_sum;
	int win_setting;

	int error_count = 0;
	int idle_cycles = 0;
	bit tx_idle_en  = 1'b1;
	bit rx_idle_en  = 1'b1;
	int hold_serial = 0;
	int hold_seen   = 0;
	int hold_left   = 0;

	sample_moving_average #(.RING_DEPTH(RING)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wen  (cfg_wen),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Update the history with one accepted sample and queue the average it yields
	task automatic predict_average(input logic signed [15:0] smp);
		int win;
		int oldest;
		int quot;
		avg_result_t res;
		win = win_setting;
		if (win == 0)
			win = 1;
		if (win > RING)
			win = RING;
		if (hist_count >= win) begin
			oldest = (hist_wr + RING - hist_count) % RING;
			hist_sum -= hist_ring[oldest];
			hist_count--;
		end
		hist_ring[hist_wr] = smp;
		hist_sum += smp;
		hist_count++;
		hist_wr = (hist_wr + 1) % RING;
		quot = hist_sum / hist_count;
		res.average = quot[15:0];
		res.held = hist_count[SMA_HELD_W-1:0];
		pending_averages.push_back(res);
	endtask

	// Pick a sample, weighted toward the extremes and values near zero
	function automatic logic [15:0] pick_sample();
		int sel;
		sel = $urandom_range(99);
		if (sel < 10)
			return 16'h7FFF;
		else if (sel < 20)
			return 16'h8000;
		else if (sel < 30)
			return 16'($signed($urandom_range(8)) - 4);
		return 16'($urandom);
	endfunction

	// Offer one sample beat, after an optional random gap, and wait until it is taken
	task automatic send_sample(input logic [15:0] smp);
		int gap;
		gap = 0;
		if (tx_idle_en && $urandom_range(99) < 35)
			gap = $urandom_range(1, 4);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= smp;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predict_average(smp);
	endtask

	// Stop offering samples and wait until the block has returned every average
	task automatic drain_block();
		s_tvalid <= 1'b0;
		while (pending_averages.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write the window register; call only while the block is idle
	task automatic write_window(input int len);
		cfg_wen   <= 1'b1;
		cfg_wdata <= len[SMA_WIN_W-1:0];
		@(posedge clk);
		cfg_wen <= 1'b0;
		win_setting = len & 'h7F;
		hist_count = 0;
		hist_sum = 0;
		@(posedge clk);
	endtask

	// Reset window, full-scale runs, sign boundaries near zero
	task automatic test_reset_extremes();
		repeat (17) send_sample(16'h8000);
		repeat (3) send_sample(16'h7FFF);
		send_sample(16'h0000);
		send_sample(16'hFFFF);
		send_sample(16'h0001);
		drain_block();
	endtask

	// Zero window, oversized window, rewrite of the same window, small windows
	task automatic test_window_settings();
		write_window(0);
		repeat (4) send_sample(pick_sample());
		drain_block();
		write_window(127);
		repeat (70) send_sample(pick_sample());
		drain_block();
		write_window(16);
		repeat (6) send_sample(pick_sample());
		drain_block();
		write_window(16);
		repeat (20) send_sample(pick_sample());
		drain_block();
		write_window(65);
		repeat (8) send_sample(pick_sample());
		drain_block();
		write_window(1);
		repeat (4) send_sample(pick_sample());
		drain_block();
		write_window(2);
		repeat (5) send_sample(pick_sample());
		drain_block();
	endtask

	// Hold the receiver off while samples keep coming, so the input stalls
	task automatic test_output_backpressure();
		write_window(8);
		hold_serial++;
		repeat (12) send_sample(pick_sample());
		drain_block();
	endtask

	// Pause the sender until every average is back, then resume mid-window
	task automatic test_sender_pause();
		write_window(64);
		repeat (10) send_sample(pick_sample());
		s_tvalid <= 1'b0;
		while (pending_averages.size() != 0)
			@(posedge clk);
		repeat (10) send_sample(pick_sample());
		drain_block();
	endtask

	// Random windows and samples, one phase with both sides always ready
	task automatic test_random_stream();
		int win;
		for (int phase = 0; phase < 8; phase++) begin
			case (phase)
				0: win = 1;
				1: win = 64;
				2: win = 0;
				3: win = 127;
				default: win = $urandom_range(127);
			endcase
			write_window(win);
			tx_idle_en = (phase != 4);
			rx_idle_en = (phase != 4);
			repeat (140) send_sample(pick_sample());
			drain_block();
		end
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
	endtask

	initial begin
		win_setting = SMA_WIN_RESET;
		hist_wr = 0;
		hist_count = 0;
		hist_sum = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_extremes();
		test_window_settings();
		test_output_backpressure();
		test_sender_pause();
		test_random_stream();
		if (error_count == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end

	// Drive the receiver ready: hold-off on request, random stalls otherwise
	always @(posedge clk) begin
		if (hold_serial != hold_seen) begin
			hold_seen <= hold_serial;
			hold_left <= RX_HOLD;
			m_tready  <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready  <= 1'b0;
		end else if (rx_idle_en && $urandom_range(99) < 35) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Compare each result beat with the oldest predicted average
	always @(posedge clk) begin : check_beat
		avg_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_averages.size() == 0) begin
				$display("%0t: unexpected beat: expected none, actual average %0d held %0d",
					$realtime, $signed(m_tdata[15:0]), m_tdata[22:16]);
				error_count++;
			end else begin
				want = pending_averages.pop_front();
				if (m_tdata[15:0] !== want.average) begin
					$display("%0t: average mismatch: expected %0d, actual %0d",
						$realtime, want.average, $signed(m_tdata[15:0]));
					error_count++;
				end
				if (m_tdata[22:16] !== want.held) begin
					$display("%0t: samples_held mismatch: expected %0d, actual %0d",
						$realtime, want.held, m_tdata[22:16]);
					error_count++;
				end
			end
		end
	end

	// Abandon the run when no beat or write moves for too long
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wen) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("tb_top: FAIL");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule

// ===== files.f =====
+incdir+src
src/sma_pkg.sv
src/sma_ram.sv
src/sma_dp.sv
src/sma_seq.sv
src/sample_moving_average.sv
tb/tb_top.sv
